// File: sv/acir_pkg.sv
// Shared types, constants and code tables for the AC IR command frame encoder.
package acir_pkg;

    localparam int DUR_W      = 16;
    localparam int DATA_W     = 32;
    localparam int NUM_REGS   = 7;
    localparam int REG_IDX_W  = 3;
    localparam int ADDR_W     = REG_IDX_W + 2;
    localparam int NUM_PAIRS  = 50;
    localparam int PAIR_W     = 6;
    localparam int FRAME_W    = 48;
    localparam int STEP_COUNT = 34;

    typedef logic [DUR_W-1:0] dur_t;

    typedef enum logic [1:0] {
        OP_SET       = 2'd0,
        OP_TOGGLE    = 2'd1,
        OP_TIMER_ON  = 2'd2,
        OP_TIMER_OFF = 2'd3
    } opcode_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_LEADER_MARK  = 3'd0,
        REG_LEADER_SPACE = 3'd1,
        REG_BIT_MARK     = 3'd2,
        REG_ZERO_SPACE   = 3'd3,
        REG_ONE_SPACE    = 3'd4,
        REG_STOP_MARK    = 3'd5,
        REG_FRAME_GAP    = 3'd6
    } reg_idx_t;

    localparam logic [2:0] MODE_OFF  = 3'd0;
    localparam logic [2:0] MODE_AUTO = 3'd2;
    localparam logic [2:0] MODE_DRY  = 3'd3;
    localparam logic [2:0] MODE_FAN  = 3'd5;

    localparam logic [2:0] TOG_POWER_OFF = 3'd0;
    localparam logic [2:0] TOG_SWING     = 3'd1;
    localparam logic [2:0] TOG_LAST      = 3'd5;

    localparam logic [7:0] TEMP_MIN     = 8'd17;
    localparam logic [7:0] TEMP_MAX     = 8'd30;
    localparam logic [7:0] TEMP_DEFAULT = 8'd24;

    localparam logic [PAIR_W-1:0] PAIR_LEADER = PAIR_W'(0);
    localparam logic [PAIR_W-1:0] PAIR_STOP   = PAIR_W'(NUM_PAIRS - 1);

    localparam logic [7:0] HDR0        = 8'h4D;
    localparam logic [7:0] HDR1        = 8'hB2;
    localparam logic [7:0] ALT_HDR0    = 8'hAD;
    localparam logic [7:0] ALT_HDR1    = 8'h52;
    localparam logic [7:0] ALT_HDR2    = 8'hAF;
    localparam logic [7:0] ALT_HDR3    = 8'h50;
    localparam logic [7:0] FAN_FIXED   = 8'hF8;
    localparam logic [7:0] MT_FAN_MODE = 8'h27;
    localparam logic [7:0] TIMER_ON_X  = 8'hC0;
    localparam logic [7:0] TIMER_OFF_T = 8'hFE;

    localparam logic [FRAME_W-1:0] PWR_OFF_FRAME = {8'hF8, 8'h07, 8'h21, 8'hDE, 8'hB2, 8'h4D};
    localparam logic [FRAME_W-1:0] SWING_CMD     = {8'hF8, 8'h07, 8'h29, 8'hD6, 8'hB2, 8'h4D};

    function automatic dur_t reg_reset(input logic [REG_IDX_W-1:0] idx);
        dur_t v;
        v = '0;
        unique case (idx)
            REG_LEADER_MARK:  v = dur_t'(4480);
            REG_LEADER_SPACE: v = dur_t'(4480);
            REG_BIT_MARK:     v = dur_t'(560);
            REG_ZERO_SPACE:   v = dur_t'(560);
            REG_ONE_SPACE:    v = dur_t'(1680);
            REG_STOP_MARK:    v = dur_t'(560);
            REG_FRAME_GAP:    v = dur_t'(5040);
            default:          v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [3:0] temp_nibble(input logic [3:0] idx);
        logic [3:0] v;
        v = 4'h0;
        unique case (idx)
            4'd0:    v = 4'h0;
            4'd1:    v = 4'h8;
            4'd2:    v = 4'hC;
            4'd3:    v = 4'h4;
            4'd4:    v = 4'h6;
            4'd5:    v = 4'hE;
            4'd6:    v = 4'hA;
            4'd7:    v = 4'h2;
            4'd8:    v = 4'h3;
            4'd9:    v = 4'hB;
            4'd10:   v = 4'h9;
            4'd11:   v = 4'h1;
            4'd12:   v = 4'h5;
            4'd13:   v = 4'hD;
            default: v = 4'h0;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] fan_code(input logic [1:0] fan);
        logic [7:0] v;
        v = 8'hFD;
        unique case (fan)
            2'd0: v = 8'hFD;
            2'd1: v = 8'hF9;
            2'd2: v = 8'hFA;
            2'd3: v = 8'hFC;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] mode_nib(input logic [2:0] mode);
        logic [7:0] v;
        v = 8'h00;
        unique case (mode)
            3'd2:    v = 8'h10;
            3'd3:    v = 8'h20;
            3'd4:    v = 8'h30;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] tog_code(input logic [2:0] tog);
        logic [7:0] v;
        v = 8'h00;
        unique case (tog)
            3'd2:    v = 8'hA5;
            3'd3:    v = 8'h45;
            3'd4:    v = 8'hC5;
            3'd5:    v = 8'h55;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] step_base(input logic [5:0] si);
        logic [7:0] v;
        v = 8'h80;
        unique case (si)
            6'd0:  v = 8'h80;  6'd1:  v = 8'hC0;  6'd2:  v = 8'hA0;  6'd3:  v = 8'hE0;
            6'd4:  v = 8'h90;  6'd5:  v = 8'hD0;  6'd6:  v = 8'hB0;  6'd7:  v = 8'hF0;
            6'd8:  v = 8'h88;  6'd9:  v = 8'hC8;  6'd10: v = 8'hA8;  6'd11: v = 8'hE8;
            6'd12: v = 8'h98;  6'd13: v = 8'hD8;  6'd14: v = 8'hB8;  6'd15: v = 8'hF8;
            6'd16: v = 8'h80;  6'd17: v = 8'hC0;  6'd18: v = 8'hA0;  6'd19: v = 8'hE0;
            6'd20: v = 8'hD0;  6'd21: v = 8'hF0;  6'd22: v = 8'hC8;  6'd23: v = 8'hE8;
            6'd24: v = 8'hD8;  6'd25: v = 8'hF8;  6'd26: v = 8'hC0;  6'd27: v = 8'hE0;
            6'd28: v = 8'hD0;  6'd29: v = 8'hF0;  6'd30: v = 8'hC8;  6'd31: v = 8'hE8;
            6'd32: v = 8'hD8;  6'd33: v = 8'hF8;
            default: v = 8'h80;
        endcase
        return v;
    endfunction

endpackage

// File: sv/ac_ir_command_frame_encoder_core.sv
// Top level of the AC IR command frame encoder: command register, frame build, pulse serialiser.
//
// Usage:
//   Command channel (in_valid/in_ready) takes one command per transaction: opcode, mode, fan,
//   temperature, toggle kind, timer step and copy index. Result channel (out_valid/out_ready)
//   returns mark/space pairs in microseconds: a leader pair, 48 data-bit pairs (bytes 0..5,
//   LSB first) and a stop pair flagged with last. An invalid command returns a single
//   transaction with error and last set and zero durations.
//   Durations come from seven 16-bit registers on the APB port at byte address 4*i; write
//   them only while no command is in flight. pready is tied high.
//   Throughput: one pair per cycle while out_ready does not stall the result register; the
//   serialiser's pair counter sets the pairs per command. Rejected commands back to back leave
//   gaps between their results, since the command register takes a new command only in the
//   cycle after it hands the last one on. One command waits in the command register while the
//   previous frame is still being sent, and it loads on the same edge that the stop pair
//   leaves, so frames follow without a gap.
//   Receiver stall: the result register holds its pair and the serialiser stops; once the
//   command register is full, in_ready drops.
//   Reset: empties the command register, serialiser and result register and restores the
//   default durations.
module ac_ir_command_frame_encoder_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [acir_pkg::ADDR_W-1:0]  paddr,
    input  logic [acir_pkg::DATA_W-1:0]  pwdata,
    output logic [acir_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   opcode,
    input  logic [2:0]                   ac_mode,
    input  logic [1:0]                   fan_speed,
    input  logic [7:0]                   temperature,
    input  logic [2:0]                   toggle_kind,
    input  logic [5:0]                   timer_slot,
    input  logic                         copy_index,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [acir_pkg::DUR_W-1:0]   mark_us,
    output logic [acir_pkg::DUR_W-1:0]   space_us,
    output logic                         error,
    output logic                         last
);
    import acir_pkg::*;

    dur_t                  regs_reg [NUM_REGS];
    logic [REG_IDX_W-1:0]  cfg_idx;
    logic                  cfg_wr;

    logic                  in_valid_reg, in_valid_next;
    opcode_t               op_reg;
    logic [2:0]            mode_reg;
    logic [1:0]            fan_reg;
    logic [7:0]            temp_reg;
    logic [2:0]            tog_reg;
    logic [5:0]            step_reg;
    logic                  copy_in_reg;

    logic                  busy_reg, busy_next;
    logic                  err_reg;
    logic                  copy_reg;
    logic [PAIR_W-1:0]     idx_reg, idx_next;
    logic [FRAME_W-1:0]    frame_reg, frame_next;

    logic                  out_valid_reg, out_valid_next;
    dur_t                  mark_reg, mark_next;
    dur_t                  space_reg, space_next;
    logic                  error_reg, error_next;
    logic                  last_reg, last_next;

    logic                  ok;
    logic [FRAME_W-1:0]    frame_built;
    logic [7:0]            fb, mt, t_adj, t_off, tb, fr4, fr5;
    logic [5:0]            si;
    logic                  step_ok;
    logic                  adv, finishing, load;

    // Configuration port
    assign pready  = 1'b1;
    assign cfg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                regs_reg[i] <= reg_reset(REG_IDX_W'(i));
            end
        end
        else if (cfg_wr && (cfg_idx < REG_IDX_W'(NUM_REGS)))
        begin
            regs_reg[cfg_idx] <= pwdata[DUR_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (cfg_idx < REG_IDX_W'(NUM_REGS))
        begin
            prdata = DATA_W'(regs_reg[cfg_idx]);
        end
    end

    // Frame build from the command register
    always_comb
    begin
        step_ok = (step_reg >= 6'd1) && (step_reg <= 6'(STEP_COUNT));
        si      = step_ok ? (step_reg - 6'd1) : 6'd0;

        ok = (mode_reg <= MODE_FAN);
        if ((op_reg == OP_SET || op_reg == OP_TIMER_ON) && mode_reg == MODE_OFF)
        begin
            ok = 1'b0;
        end
        if (op_reg == OP_TOGGLE && tog_reg > TOG_LAST)
        begin
            ok = 1'b0;
        end
        if ((op_reg == OP_TIMER_ON || op_reg == OP_TIMER_OFF) && !step_ok)
        begin
            ok = 1'b0;
        end

        fb = (mode_reg == MODE_AUTO || mode_reg == MODE_DRY) ? FAN_FIXED : fan_code(fan_reg);

        t_adj = (temp_reg < TEMP_MIN || temp_reg > TEMP_MAX) ? TEMP_DEFAULT : temp_reg;
        t_off = t_adj - TEMP_MIN;
        mt = (mode_reg == MODE_FAN) ? MT_FAN_MODE
                                    : (mode_nib(mode_reg) | {4'h0, temp_nibble(t_off[3:0])});

        tb = step_base(si);

        frame_built = '0;
        fr4 = 8'h00;
        fr5 = 8'h00;
        unique case (op_reg)
            OP_SET:
            begin
                frame_built = {~mt, mt, ~fb, fb, HDR1, HDR0};
            end
            OP_TOGGLE:
            begin
                fr4 = tog_code(tog_reg);
                priority if (tog_reg == TOG_POWER_OFF)
                begin
                    frame_built = PWR_OFF_FRAME;
                end
                else if (tog_reg == TOG_SWING)
                begin
                    frame_built = SWING_CMD;
                end
                else
                begin
                    frame_built = {~fr4, fr4, ALT_HDR3, ALT_HDR2, ALT_HDR1, ALT_HDR0};
                end
            end
            OP_TIMER_ON:
            begin
                fr4 = mt ^ TIMER_ON_X;
                priority if (si >= 6'd26)
                begin
                    fr5 = tb | 8'h02;
                end
                else if (si >= 6'd16)
                begin
                    fr5 = tb | 8'h04;
                end
                else
                begin
                    fr5 = tb;
                end
                frame_built = {fr5, fr4, ~fb, fb, HDR1, HDR0};
            end
            OP_TIMER_OFF:
            begin
                priority if (si >= 6'd26)
                begin
                    fr4 = mt | 8'h40;
                end
                else if (si >= 6'd16)
                begin
                    fr4 = mt | 8'h80;
                end
                else
                begin
                    fr4 = mt;
                end
                frame_built = {TIMER_OFF_T, fr4, ~tb, tb, HDR1, HDR0};
            end
        endcase
    end

    // Serialiser and result register
    assign adv       = !out_valid_reg || out_ready;
    assign finishing = err_reg || (idx_reg == PAIR_STOP);
    assign load      = in_valid_reg && (!busy_reg || (adv && finishing));
    assign in_ready  = !in_valid_reg;

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        frame_next     = frame_reg;
        out_valid_next = out_valid_reg;
        mark_next      = mark_reg;
        space_next     = space_reg;
        error_next     = error_reg;
        last_next      = last_reg;

        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
        end

        if (adv)
        begin
            out_valid_next = busy_reg;
        end

        if (busy_reg && adv)
        begin
            error_next = 1'b0;
            last_next  = 1'b0;
            idx_next   = idx_reg + PAIR_W'(1);
            priority if (err_reg)
            begin
                mark_next  = '0;
                space_next = '0;
                error_next = 1'b1;
                last_next  = 1'b1;
                busy_next  = 1'b0;
            end
            else if (idx_reg == PAIR_LEADER)
            begin
                mark_next  = regs_reg[REG_LEADER_MARK];
                space_next = regs_reg[REG_LEADER_SPACE];
            end
            else if (idx_reg == PAIR_STOP)
            begin
                mark_next  = regs_reg[REG_STOP_MARK];
                space_next = copy_reg ? dur_t'(0) : regs_reg[REG_FRAME_GAP];
                last_next  = 1'b1;
                busy_next  = 1'b0;
            end
            else
            begin
                mark_next  = regs_reg[REG_BIT_MARK];
                space_next = frame_reg[0] ? regs_reg[REG_ONE_SPACE] : regs_reg[REG_ZERO_SPACE];
                frame_next = frame_reg >> 1;
            end
        end

        if (load)
        begin
            in_valid_next = 1'b0;
            busy_next     = 1'b1;
            idx_next      = PAIR_LEADER;
            frame_next    = frame_built;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= PAIR_LEADER;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg      <= opcode_t'(opcode);
            mode_reg    <= ac_mode;
            fan_reg     <= fan_speed;
            temp_reg    <= temperature;
            tog_reg     <= toggle_kind;
            step_reg    <= timer_slot;
            copy_in_reg <= copy_index;
        end
        if (load)
        begin
            err_reg  <= !ok;
            copy_reg <= copy_in_reg;
        end
        frame_reg <= frame_next;
        mark_reg  <= mark_next;
        space_reg <= space_next;
        error_reg <= error_next;
        last_reg  <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign mark_us   = mark_reg;
    assign space_us  = space_reg;
    assign error     = error_reg;
    assign last      = last_reg;

endmodule

// File: sv/acir_checker.sv
// Port-level checker for the AC IR command frame encoder, bound to the top level.
module acir_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         pready,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [acir_pkg::DUR_W-1:0]   mark_us,
    input logic [acir_pkg::DUR_W-1:0]   space_us,
    input logic                         error,
    input logic                         last
);
    import acir_pkg::*;

    // Hold a stalled result until it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result transaction dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(mark_us) && $stable(space_us)
                                    && $stable(error) && $stable(last))
        else $error("stalled result payload changed");

    // Rejected command: one zero-length transaction that closes the run
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> last && mark_us == '0 && space_us == '0)
        else $error("malformed error result");

    // Drop in_ready only after taking a command
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(in_valid && in_ready) && pready)
        else $error("in_ready fell without a command transaction");

endmodule

bind ac_ir_command_frame_encoder_core acir_checker u_acir_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .mark_us   (mark_us),
    .space_us  (space_us),
    .error     (error),
    .last      (last)
);
